[hw/rtl/lkcr_pkg.sv]
// lkcr_pkg: shared constants, types and arithmetic helpers for the keystream
// character rotator. No dependencies.
package lkcr_pkg;

  localparam int LKCR_GEN_W   = 17;
  localparam int LKCR_BYTE_W  = 8;
  localparam int LKCR_KEY_W   = 7;
  localparam int LKCR_ADDR_W  = 3;
  localparam int LKCR_DATA_W  = 32;

  localparam logic [LKCR_GEN_W-1:0]  LKCR_SEED_RST = 17'd1;
  localparam logic [LKCR_GEN_W-1:0]  LKCR_MOD      = 17'd65537;
  localparam logic [LKCR_GEN_W-1:0]  LKCR_GEN_MAX  = 17'd65536;
  localparam logic [23:0]            LKCR_MULT     = 24'd75;
  localparam logic [LKCR_BYTE_W-1:0] LKCR_BASE     = 8'd32;
  localparam logic [LKCR_BYTE_W-1:0] LKCR_TOP      = 8'd127;
  localparam logic [LKCR_BYTE_W-1:0] LKCR_SPAN     = 8'd96;
  // floor(x/3) = (x * 5462) >> 14 for any 12-bit x
  localparam logic [25:0]            LKCR_RECIP3   = 26'd5462;

  typedef enum logic {
    LKCR_REG_SEED = 1'b0,
    LKCR_REG_MODE = 1'b1
  } lkcr_reg_t;

  typedef struct packed {
    logic [LKCR_GEN_W-1:0] seed;
    logic                  decrypt;
  } lkcr_cfg_t;

  // one generator step: v*75 mod 65537 by folding the high part
  function automatic logic [LKCR_GEN_W-1:0] lkcr_advance(input logic [LKCR_GEN_W-1:0] v);
    logic [23:0] p;
    logic [15:0] lo;
    logic [7:0]  hi;
    p  = {7'd0, v} * LKCR_MULT;
    lo = p[15:0];
    hi = p[23:16];
    if (lo >= {8'd0, hi}) begin
      return {1'b0, lo} - {9'd0, hi};
    end else begin
      return {1'b0, lo} + LKCR_MOD - {9'd0, hi};
    end
  endfunction

  // r mod 96: low five bits pass, the rest is reduced mod 3
  function automatic logic [LKCR_KEY_W-1:0] lkcr_mod96(input logic [LKCR_GEN_W-1:0] r);
    logic [11:0] x;
    logic [25:0] prod;
    logic [11:0] q;
    logic [11:0] rem;
    x    = r[16:5];
    prod = {14'd0, x} * LKCR_RECIP3;
    q    = prod[25:14];
    rem  = x - ({q[10:0], 1'b0} + q);
    return {rem[1:0], r[4:0]};
  endfunction

  function automatic logic [LKCR_BYTE_W-1:0] lkcr_rotate(input logic [LKCR_BYTE_W-1:0] b,
                                                         input logic [LKCR_KEY_W-1:0]  k,
                                                         input logic                   dec);
    logic [LKCR_BYTE_W-1:0] off;
    logic [LKCR_BYTE_W-1:0] s;
    off = b - LKCR_BASE;
    if (dec) begin
      s = off + LKCR_SPAN - {1'b0, k};
    end else begin
      s = off + {1'b0, k};
    end
    if (s >= LKCR_SPAN) begin
      s = s - LKCR_SPAN;
    end
    if ((b < LKCR_BASE) || (b > LKCR_TOP)) begin
      return b;
    end else begin
      return s + LKCR_BASE;
    end
  endfunction

endpackage

[hw/rtl/lkcr_regs.sv]
// lkcr_regs: configuration register file behind the register bus port.
// Depends on lkcr_pkg.
module lkcr_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lkcr_pkg::LKCR_ADDR_W-1:0] paddr,
  input  logic [lkcr_pkg::LKCR_DATA_W-1:0] pwdata,
  output logic [lkcr_pkg::LKCR_DATA_W-1:0] prdata,
  output logic                            pready,
  output lkcr_pkg::lkcr_cfg_t             cfg
);
  import lkcr_pkg::*;

  logic [LKCR_GEN_W-1:0] seed_r;
  logic                  mode_r;
  logic                  wr_en;
  lkcr_reg_t             reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  // only address bit 2 selects a register; other bits are ignored
  assign reg_sel = lkcr_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= LKCR_SEED_RST;
      mode_r <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        LKCR_REG_SEED: seed_r <= pwdata[LKCR_GEN_W-1:0];
        LKCR_REG_MODE: mode_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      LKCR_REG_SEED: prdata = {{(LKCR_DATA_W-LKCR_GEN_W){1'b0}}, seed_r};
      LKCR_REG_MODE: prdata = {{(LKCR_DATA_W-1){1'b0}}, mode_r};
      default:       prdata = '0;
    endcase
  end

  assign cfg.seed    = seed_r;
  assign cfg.decrypt = mode_r;

endmodule

[hw/rtl/lkcr_pipe.sv]
// lkcr_pipe: three-stage byte pipeline (input register, generator step,
// rotation into the result register). Depends on lkcr_pkg.
module lkcr_pipe (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lkcr_pkg::lkcr_cfg_t              cfg,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lkcr_pkg::LKCR_BYTE_W-1:0] in_tdata,
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lkcr_pkg::LKCR_BYTE_W-1:0] out_tdata
);
  import lkcr_pkg::*;

  logic                   s1_valid_r;
  logic [LKCR_BYTE_W-1:0] s1_byte_r;
  logic                   s1_first_r;
  logic                   s2_valid_r;
  logic [LKCR_BYTE_W-1:0] s2_byte_r;
  logic                   out_valid_r;
  logic [LKCR_BYTE_W-1:0] out_data_r;
  logic [LKCR_GEN_W-1:0]  gen_r;
  logic [LKCR_GEN_W-1:0]  gen_nxt;
  logic [LKCR_BYTE_W-1:0] out_data_nxt;

  logic out_free;
  logic s2_adv;
  logic s2_free;
  logic s1_adv;
  logic s1_free;
  logic in_xfer;

  assign out_free  = !out_valid_r || out_tready;
  assign s2_adv    = s2_valid_r && out_free;
  assign s2_free   = !s2_valid_r || s2_adv;
  assign s1_adv    = s1_valid_r && s2_free;
  assign s1_free   = !s1_valid_r || s1_adv;
  assign in_tready = s1_free;
  assign in_xfer   = in_tvalid && in_tready;

  // generator steps once per byte, reloaded from the seed on a first byte
  assign gen_nxt      = lkcr_advance(s1_first_r ? cfg.seed : gen_r);
  assign out_data_nxt = lkcr_rotate(s2_byte_r, lkcr_mod96(gen_r), cfg.decrypt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      gen_r       <= LKCR_SEED_RST;
    end else begin
      if (s1_free) begin
        s1_valid_r <= in_tvalid;
      end
      if (s2_free) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_free) begin
        out_valid_r <= s2_valid_r;
      end
      if (s1_adv) begin
        gen_r <= gen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r  <= in_tdata;
      s1_first_r <= in_tuser;
    end
    if (s1_adv) begin
      s2_byte_r <= s1_byte_r;
    end
    if (s2_adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_gen_range: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> (gen_r <= LKCR_GEN_MAX))
    else $error("generator left its range after a step");

  a_gen_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(gen_r))
    else $error("generator moved without a byte");

  a_passthru: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_adv && ((s2_byte_r < LKCR_BASE) || (s2_byte_r > LKCR_TOP)))
      |=> (out_data_r == $past(s2_byte_r)))
    else $error("byte outside printable range was altered");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && s2_valid_r && out_valid_r))
    else $error("input stalled with a free stage");
`endif

endmodule

[hw/rtl/lehmer_keystream_char_rotator.sv]
// lehmer_keystream_char_rotator: top level, register port plus byte pipeline.
// Depends on lkcr_pkg, lkcr_regs and lkcr_pipe.
//
//   channel   direction  handshake             payload
//   in_*      sink       in_tvalid/in_tready   tdata: data_in; tuser: first
//   out_*     source     out_tvalid/out_tready tdata: data_out
//   p*        register   psel/penable/pready   seed at 0x0, mode at 0x4
//
// one byte per cycle sustained while out_tready is high; a byte travels to
// result valid via input register, generator step and rotation register
// the generator register is the only loop: it steps once per byte
// reset is synchronous; seed resets to 1, mode to encrypt, pipeline empty
// a stalled output backs up through all three stages before in_tready drops
module lehmer_keystream_char_rotator (
  input  logic                             clk,
  input  logic                             rst_n,
  // bits [7:0] data_in
  input  logic [lkcr_pkg::LKCR_BYTE_W-1:0] in_tdata,
  // bit [0] first
  input  logic                             in_tuser,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // bits [7:0] data_out
  output logic [lkcr_pkg::LKCR_BYTE_W-1:0] out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lkcr_pkg::LKCR_ADDR_W-1:0] paddr,
  input  logic [lkcr_pkg::LKCR_DATA_W-1:0] pwdata,
  output logic [lkcr_pkg::LKCR_DATA_W-1:0] prdata,
  output logic                             pready
);
  import lkcr_pkg::*;

  lkcr_cfg_t cfg;

  lkcr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lkcr_pipe u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
